[rtl/core/ring_buffer_fifo_macros.svh]
// Assertion macros for the ring buffer FIFO.
// Needs nothing else; included by the top level only.
`ifndef RING_BUFFER_FIFO_MACROS_SVH
`define RING_BUFFER_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rbf_pkg.sv]
// Shared types and constants of the ring buffer FIFO.
// Used by the front, the back and the top level; depends on nothing.
package rbf_pkg;

  localparam int OP_W       = 2;
  localparam int DATA_W     = 32;
  localparam int OFS_W      = 4;
  localparam int REQ_W      = 5;
  localparam int CAP_W      = 5;
  localparam int OCC_W      = 5;
  localparam int MAX_BURST  = 16;
  localparam int BURST_W    = $clog2(MAX_BURST + 1);
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_BURST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_REFUSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } cmd_ctrl_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } res_t;

endpackage

[rtl/core/rbf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/rbf_queue.sv]
// Small synchronous queue of flat words, used between front and back and for results.
// Depends on nothing.
module rbf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       ready,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       valid,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_push, do_pop;

  assign ready   = (level_r != LW'(DEPTH));
  assign valid   = (level_r != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[head_r];
  assign level   = level_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    level_nxt = level_r;
    if (do_push) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= wdata;
    end
  end

endmodule

[rtl/core/rbf_front.sv]
// Front end: accepts requests, keeps head, tail, count and capacity, and turns
// each request into slot commands. Depends on rbf_pkg.
module rbf_front import rbf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [OP_W-1:0]          op,
  input  logic [DATA_W-1:0]        value,
  input  logic [OFS_W-1:0]         offset,
  input  logic [REQ_W-1:0]         request_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_capacity_in_use,
  output logic                     cmd_valid,
  output cmd_ctrl_t                cmd_ctrl,
  output logic [$clog2(DEPTH)-1:0] cmd_addr,
  output logic [DATA_W-1:0]        cmd_wdata,
  input  logic                     cmd_ready
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int SW      = ((CW > OFS_W) ? CW : OFS_W) + 1;
  localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  logic [AW-1:0]      rd_pos_r, rd_pos_nxt, wr_pos_r, wr_pos_nxt;
  logic [CW-1:0]      count_r, count_nxt, cap_r, cap_nxt;
  logic [BURST_W-1:0] left_r, left_nxt, burst_n;
  logic [SW-1:0]      peek_sum;
  logic [AW-1:0]      peek_addr, rd_pos_inc, wr_pos_inc;
  logic               accept;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(p) + CW'(1);
    return (s == c) ? '0 : AW'(s);
  endfunction

  assign full       = (left_r != '0) || !cmd_ready;
  assign cfg_ready  = (left_r == '0);
  assign accept     = push && !full;
  assign rd_pos_inc = wrap_inc(rd_pos_r, cap_r);
  assign wr_pos_inc = wrap_inc(wr_pos_r, cap_r);
  assign peek_sum   = SW'(rd_pos_r) + SW'(offset);
  assign peek_addr  = (peek_sum >= SW'(cap_r)) ? AW'(peek_sum - SW'(cap_r)) : AW'(peek_sum);

  always_comb begin
    if (32'(request_count) > MAX_BURST) begin
      burst_n = BURST_W'(MAX_BURST);
    end else begin
      burst_n = BURST_W'(request_count);
    end
    if (32'(count_r) < 32'(burst_n)) begin
      burst_n = BURST_W'(count_r);
    end
  end

  always_comb begin
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    left_nxt   = left_r;
    cmd_valid  = 1'b0;
    cmd_ctrl   = '{kind: CMD_REFUSE, occupancy: OCC_W'(count_r), last: 1'b1};
    cmd_addr   = rd_pos_r;
    cmd_wdata  = value;
    if (left_r != '0) begin
      if (cmd_ready) begin
        cmd_valid          = 1'b1;
        cmd_ctrl.kind      = CMD_READ;
        cmd_ctrl.occupancy = OCC_W'(count_r - 1'b1);
        cmd_ctrl.last      = (left_r == BURST_W'(1));
        rd_pos_nxt         = rd_pos_inc;
        count_nxt          = count_r - 1'b1;
        left_nxt           = left_r - 1'b1;
      end
    end else if (accept) begin
      cmd_valid = 1'b1;
      case (op)
        OP_PUSH: begin
          if (count_r < cap_r) begin
            cmd_ctrl.kind      = CMD_WRITE;
            cmd_ctrl.occupancy = OCC_W'(count_r + 1'b1);
            cmd_addr           = wr_pos_r;
            wr_pos_nxt         = wr_pos_inc;
            count_nxt          = count_r + 1'b1;
          end
        end
        OP_POP: begin
          if (count_r != '0) begin
            cmd_ctrl.kind      = CMD_READ;
            cmd_ctrl.occupancy = OCC_W'(count_r - 1'b1);
            rd_pos_nxt         = rd_pos_inc;
            count_nxt          = count_r - 1'b1;
          end
        end
        OP_PEEK: begin
          if (32'(offset) < 32'(count_r)) begin
            cmd_ctrl.kind = CMD_READ;
            cmd_addr      = peek_addr;
          end
        end
        OP_BURST: begin
          if (burst_n != '0) begin
            cmd_ctrl.kind      = CMD_READ;
            cmd_ctrl.occupancy = OCC_W'(count_r - 1'b1);
            cmd_ctrl.last      = (burst_n == BURST_W'(1));
            rd_pos_nxt         = rd_pos_inc;
            count_nxt          = count_r - 1'b1;
            left_nxt           = burst_n - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_capacity_in_use == '0) begin
        cap_nxt = CW'(1);
      end else if (32'(cfg_capacity_in_use) > DEPTH) begin
        cap_nxt = CW'(DEPTH);
      end else begin
        cap_nxt = CW'(cfg_capacity_in_use);
      end
      rd_pos_nxt = '0;
      wr_pos_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r <= '0;
      wr_pos_r <= '0;
      count_r  <= '0;
      cap_r    <= CW'(CAP_RST);
      left_r   <= '0;
    end else begin
      rd_pos_r <= rd_pos_nxt;
      wr_pos_r <= wr_pos_nxt;
      count_r  <= count_nxt;
      cap_r    <= cap_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

[rtl/core/rbf_back.sv]
// Back end: executes slot commands against the slot RAM and forms results.
// Depends on rbf_pkg, rbf_ram.
module rbf_back import rbf_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  cmd_ctrl_t                cmd_ctrl,
  input  logic [$clog2(DEPTH)-1:0] cmd_addr,
  input  logic [DATA_W-1:0]        cmd_wdata,
  output logic                     cmd_pop,
  input  logic [OUTQ_LW-1:0]       res_level,
  output logic                     res_valid,
  output res_t                     res
);

  logic                    s1_valid_r;
  cmd_ctrl_t               s1_ctrl_r;
  logic [ELEMENT_BITS-1:0] rd_data;
  logic                    ram_we, ram_re;

  assign cmd_pop = cmd_valid && ((32'(res_level) + 32'(s1_valid_r)) < OUTQ_DEPTH);
  assign ram_we  = cmd_pop && (cmd_ctrl.kind == CMD_WRITE);
  assign ram_re  = cmd_pop && (cmd_ctrl.kind == CMD_READ);

  rbf_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_addr),
    .wdata (ELEMENT_BITS'(cmd_wdata)),
    .re    (ram_re),
    .raddr (cmd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_ctrl_r <= cmd_ctrl;
    end
  end

  assign res_valid     = s1_valid_r;
  assign res.ok        = (s1_ctrl_r.kind != CMD_REFUSE);
  assign res.data      = (s1_ctrl_r.kind == CMD_READ) ? DATA_W'(rd_data) : '0;
  assign res.occupancy = s1_ctrl_r.occupancy;
  assign res.last      = s1_ctrl_r.last;

endmodule

[rtl/core/ring_buffer_fifo.sv]
// Each result passes the command queue, the back end's result register and the result queue.
// Push, pop and peek each need one accepted request; once a burst pop of n elements is
// accepted, full stays high until its n slot commands are issued, one per cycle while
// the command queue has room. Full also stays high while a stalled result side fills
// the command queue. Reset clears head, tail, count and both internal queues and sets
// capacity to 16 (or DEPTH if smaller); slot contents are not cleared.
// Top level of the ring buffer FIFO. Depends on rbf_pkg, rbf_front, rbf_back,
// rbf_queue, rbf_ram and ring_buffer_fifo_macros.svh.
`include "ring_buffer_fifo_macros.svh"
module ring_buffer_fifo import rbf_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   in_op,
  input  logic [DATA_W-1:0] in_value,
  input  logic [OFS_W-1:0]  in_offset,
  input  logic [REQ_W-1:0]  in_request_count,
  output logic              empty,
  input  logic              pop,
  output logic              out_ok,
  output logic [DATA_W-1:0] out_data,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_capacity_in_use
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CMD_W = $bits(cmd_ctrl_t) + AW + DATA_W;

  cmd_ctrl_t          cmd_ctrl, q_ctrl;
  logic [AW-1:0]      cmd_addr, q_addr;
  logic [DATA_W-1:0]  cmd_wdata, q_wdata;
  logic               cmd_valid, cmdq_ready, q_valid, cmd_pop;
  logic [CMD_W-1:0]   cmdq_rdata;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cmdq_level;
  res_t               res, out_res;
  logic               res_valid, outq_ready, outq_valid;
  logic [OUTQ_LW-1:0] outq_level;

  rbf_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .op                  (in_op),
    .value               (in_value),
    .offset              (in_offset),
    .request_count       (in_request_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .cmd_valid           (cmd_valid),
    .cmd_ctrl            (cmd_ctrl),
    .cmd_addr            (cmd_addr),
    .cmd_wdata           (cmd_wdata),
    .cmd_ready           (cmdq_ready)
  );

  rbf_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_valid),
    .wdata ({cmd_ctrl, cmd_addr, cmd_wdata}),
    .ready (cmdq_ready),
    .pop   (cmd_pop),
    .rdata (cmdq_rdata),
    .valid (q_valid),
    .level (cmdq_level)
  );

  assign {q_ctrl, q_addr, q_wdata} = cmdq_rdata;

  rbf_back #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ctrl  (q_ctrl),
    .cmd_addr  (q_addr),
    .cmd_wdata (q_wdata),
    .cmd_pop   (cmd_pop),
    .res_level (outq_level),
    .res_valid (res_valid),
    .res       (res)
  );

  rbf_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .ready (outq_ready),
    .pop   (pop),
    .rdata (out_res),
    .valid (outq_valid),
    .level (outq_level)
  );

  assign empty         = !outq_valid;
  assign out_ok        = out_res.ok;
  assign out_data      = out_res.data;
  assign out_occupancy = out_res.occupancy;
  assign out_last      = out_res.last;

  `RBF_ASSERT_NOW(a_cmdq_no_overflow, clk, rst_n, cmd_valid, cmdq_ready, "Command queue overflow.")
  `RBF_ASSERT_NOW(a_outq_no_overflow, clk, rst_n, res_valid, outq_ready, "Result queue overflow.")
  `RBF_ASSERT_NEXT(a_cmd_gives_result, clk, rst_n, cmd_pop, res_valid, "Command produced no result.")
  `RBF_ASSERT_NOW(a_cmdq_level_bound, clk, rst_n, cmd_pop, q_valid && (cmdq_level != '0), "Command taken from an empty queue.")

endmodule

[tb/tb_ring_buffer_fifo.sv]
// Self-checking testbench for the ring buffer FIFO: queued requests are driven through the
// push/full handshake and every result is checked against a behavioral FIFO model.
// Depends on rbf_pkg and ring_buffer_fifo; reads no files.
`timescale 1ns / 1ps

module tb_ring_buffer_fifo;
  import rbf_pkg::*;

  localparam int FIFO_DEPTH = 16;

  typedef struct packed {
    op_e              op;
    logic [DATA_W-1:0] value;
    logic [OFS_W-1:0]  offset;
    logic [REQ_W-1:0]  request_count;
  } fifo_request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [OP_W-1:0]   in_op = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic [OFS_W-1:0]  in_offset = '0;
  logic [REQ_W-1:0]  in_request_count = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_ok;
  logic [DATA_W-1:0] out_data;
  logic [OCC_W-1:0]  out_occupancy;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_capacity_in_use = '0;

  fifo_request_t queued_requests[$];
  res_t          awaited_results[$];
  fifo_request_t current_request;

  logic [DATA_W-1:0] slot_mem [FIFO_DEPTH];
  int head_pos = 0;
  int tail_pos = 0;
  int held = 0;
  int capacity_setting = 16;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_arm = 1'b0;
  int hold_left = 0;

  int requests_queued = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int settings_used = 0;
  int failures = 0;

  ring_buffer_fifo #(.DEPTH(FIFO_DEPTH), .ELEMENT_BITS(DATA_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_op(in_op),
    .in_value(in_value),
    .in_offset(in_offset),
    .in_request_count(in_request_count),
    .empty(empty),
    .pop(pop),
    .out_ok(out_ok),
    .out_data(out_data),
    .out_occupancy(out_occupancy),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity_in_use(cfg_capacity_in_use)
  );

  always #2 clk = ~clk;

  function automatic void await_result(input logic ok, input logic [DATA_W-1:0] data,
                                       input logic last);
    res_t r;
    r.ok = ok;
    r.data = data;
    r.occupancy = held[OCC_W-1:0];
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_fifo_op(input fifo_request_t r);
    int eff;
    int n;
    eff = (capacity_setting == 0) ? 1 :
          (capacity_setting > FIFO_DEPTH) ? FIFO_DEPTH : capacity_setting;
    case (r.op)
      OP_PUSH: begin
        if (held >= eff) begin
          await_result(1'b0, '0, 1'b1);
        end else begin
          slot_mem[tail_pos] = r.value;
          tail_pos = (tail_pos + 1) % eff;
          held++;
          await_result(1'b1, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (held == 0) begin
          await_result(1'b0, '0, 1'b1);
        end else begin
          n = head_pos;
          head_pos = (head_pos + 1) % eff;
          held--;
          await_result(1'b1, slot_mem[n], 1'b1);
        end
      end
      OP_PEEK: begin
        if (int'(r.offset) >= held) begin
          await_result(1'b0, '0, 1'b1);
        end else begin
          await_result(1'b1, slot_mem[(head_pos + int'(r.offset)) % eff], 1'b1);
        end
      end
      default: begin
        n = int'(r.request_count);
        if (n > held) n = held;
        if (n > MAX_BURST) n = MAX_BURST;
        if (n == 0) begin
          await_result(1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            int pos;
            pos = head_pos;
            head_pos = (head_pos + 1) % eff;
            held--;
            await_result(1'b1, slot_mem[pos], i == n - 1);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        predict_fifo_op(current_request);
        requests_taken++;
      end
      if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        current_request = queued_requests.pop_front();
        in_op <= current_request.op;
        in_value <= current_request.value;
        in_offset <= current_request.offset;
        in_request_count <= current_request.request_count;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  task automatic check_result;
    res_t want;
    if (awaited_results.size() == 0) begin
      $error("result with no request waiting: ok %0b, data %h", out_ok, out_data);
      failures++;
    end else begin
      want = awaited_results.pop_front();
      if (out_ok !== want.ok) begin
        $error("ok mismatch: expected %0b, actual %0b", want.ok, out_ok);
        failures++;
      end
      if (out_data !== want.data) begin
        $error("data mismatch: expected %h, actual %h", want.data, out_data);
        failures++;
      end
      if (out_occupancy !== want.occupancy) begin
        $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, out_occupancy);
        failures++;
      end
      if (out_last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
        failures++;
      end
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void queue_request(input op_e op, input logic [DATA_W-1:0] value,
                                        input logic [OFS_W-1:0] offset,
                                        input logic [REQ_W-1:0] request_count);
    fifo_request_t r;
    r.op = op;
    r.value = value;
    r.offset = offset;
    r.request_count = request_count;
    queued_requests.push_back(r);
    requests_queued++;
  endfunction

  function automatic void queue_random_request(input int push_pct);
    int roll;
    op_e op;
    logic [DATA_W-1:0] value;
    logic [OFS_W-1:0] offset;
    logic [REQ_W-1:0] request_count;
    roll = $urandom_range(99);
    if (roll < push_pct) op = OP_PUSH;
    else if (roll < push_pct + (100 - push_pct) * 2 / 5) op = OP_POP;
    else if (roll < push_pct + (100 - push_pct) * 7 / 10) op = OP_PEEK;
    else op = OP_BURST;
    case ($urandom_range(9))
      0: value = '0;
      1: value = '1;
      default: value = DATA_W'($urandom);
    endcase
    offset = $urandom_range(1) ? OFS_W'($urandom_range(3)) : OFS_W'($urandom_range(15));
    case ($urandom_range(9))
      0, 1: request_count = REQ_W'($urandom_range(16));
      2: request_count = REQ_W'($urandom_range(31));
      default: request_count = REQ_W'($urandom_range(6, 1));
    endcase
    queue_request(op, value, offset, request_count);
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_capacity_in_use <= cap;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_setting = int'(cap);
    head_pos = 0;
    tail_pos = 0;
    held = 0;
    settings_used++;
  endtask

  task automatic wait_drained;
    @(posedge clk);
    while (requests_taken != requests_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int push_pct,
                                  input int count);
    write_capacity(cap);
    for (int i = 0; i < count; i++) queue_random_request(push_pct);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Refusals on an empty buffer, value extremes, peek bounds and burst limits.
    set_idling(23, 58);
    write_capacity(5'd16);
    queue_request(OP_POP, '0, '0, '0);
    queue_request(OP_PEEK, '0, '0, '0);
    queue_request(OP_BURST, '0, '0, 5'd5);
    queue_request(OP_PUSH, 32'h0000_0000, '0, '0);
    queue_request(OP_PUSH, 32'hFFFF_FFFF, 4'hF, 5'd31);
    queue_request(OP_PUSH, 32'hA5A5_A5A5, '0, '0);
    queue_request(OP_PUSH, 32'h5A5A_5A5A, '0, '0);
    queue_request(OP_PEEK, '0, 4'd3, '0);
    queue_request(OP_PEEK, '0, 4'd4, '0);
    queue_request(OP_PEEK, '0, 4'd15, '0);
    queue_request(OP_BURST, '0, '0, 5'd0);
    queue_request(OP_POP, '0, '0, '0);
    queue_request(OP_BURST, '0, '0, 5'd16);
    queue_request(OP_PUSH, 32'h1234_5678, '0, '0);
    queue_request(OP_PUSH, 32'h8765_4321, '0, '0);
    queue_request(OP_BURST, '0, '0, 5'd31);
    wait_drained();

    // A two-slot buffer: wrap-around and the refused push when full.
    write_capacity(5'd2);
    queue_request(OP_PUSH, 32'hDEAD_BEEF, '0, '0);
    queue_request(OP_PUSH, 32'h0BAD_F00D, '0, '0);
    queue_request(OP_PUSH, 32'hCAFE_0001, '0, '0);
    queue_request(OP_PEEK, '0, 4'd1, '0);
    queue_request(OP_BURST, '0, '0, 5'd31);
    queue_request(OP_PUSH, 32'h0000_0001, '0, '0);
    wait_drained();

    run_random_phase(5'd7, 50, 50);
    run_random_phase(5'd1, 45, 50);
    run_random_phase(5'd0, 45, 50);

    set_idling(58, 23);
    run_random_phase(5'd31, 60, 50);
    run_random_phase(5'd4, 50, 50);
    run_random_phase(5'd17, 60, 50);

    // Long receiver stall while the sender keeps offering requests.
    set_idling(0, 0);
    write_capacity(5'd16);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    for (int i = 0; i < 50; i++) queue_random_request(85);
    wait_drained();

    run_random_phase(5'd12, 50, 50);

    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      failures++;
    end
    $display("Ran %0d requests giving %0d checked results across %0d capacity settings,",
             requests_taken, results_checked, settings_used);
    $display("with both sides idling at random and one long receiver stall.");
    if (failures == 0) begin
      $display("ring_buffer_fifo test passed");
    end else begin
      $display("ring_buffer_fifo test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ring_buffer_fifo test failed");
    $finish;
  end

endmodule
